// ===== hdl/mcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared sizes, codes and helpers for the multi-channel burst fifo.
// ----------------------------------------------------------------------------
package mcbf_pkg;

   // block configuration
   localparam int CHANNELS  = 4;
   localparam int DEPTH     = 1024;
   localparam int MAX_BURST = 16;

   // field widths
   localparam int CHAN_W   = 2;
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 11;
   localparam int LIMIT_W  = 5;

   // derived widths
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int CNT_W  = $clog2(MAX_BURST + 1);
   localparam int WORDS  = CHANNELS * DEPTH;
   localparam int ADDR_W = $clog2(WORDS);

   // register reset and saturation values
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
   localparam logic [COUNT_W-1:0] BATCH_SAT   = '1;

   // request codes
   typedef enum logic [0:0] {
      REQ_PUSH = 1'b0,
      REQ_PULL = 1'b1
   } req_code_type;

   // result codes
   typedef enum logic [1:0] {
      KIND_PUSH   = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   // sequencer states
   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_PULL = 1'b1
   } state_type;

   // flat sample store address of one channel slot
   function automatic logic [ADDR_W-1:0] store_addr(input logic [CHAN_W-1:0] ch,
                                                    input logic [PTR_W-1:0] ptr);
      store_addr = ADDR_W'(ch) * ADDR_W'(DEPTH) + ADDR_W'(ptr);
   endfunction

endpackage

// ===== hdl/multi_channel_burst_fifo.sv =====
// ----------------------------------------------------------------------------
// multi_channel_burst_fifo
// Per-channel ring buffers of 16-bit samples in one shared sample memory.
// ----------------------------------------------------------------------------
// Push: result registered in the cycle after the transfer; one push per cycle
//   while idle and the result side is free. Pull: samples are read through the
//   registered read port and the result register, one per cycle unless the result
//   side stalls; requests wait until the burst ends. An empty pull enters no burst.
// Reset clears pointers, fill counts, batch count and sets pull_limit to 16;
//   the sample memory is not cleared and needs no clearing pass.
module multi_channel_burst_fifo (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [mcbf_pkg::CHAN_W-1:0]         req_channel,
   input  logic signed [mcbf_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                req_batch_end,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_result_kind,
   output logic                                rsp_accepted,
   output logic [mcbf_pkg::COUNT_W-1:0]        rsp_batch_accepted,
   output logic signed [mcbf_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                rsp_burst_last,
   output logic [mcbf_pkg::COUNT_W-1:0]        rsp_fill_level,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcbf_pkg::LIMIT_W-1:0]        csr_pull_limit
);

   localparam int CHANNELS = mcbf_pkg::CHANNELS;
   localparam int PTR_W    = mcbf_pkg::PTR_W;
   localparam int FILL_W   = mcbf_pkg::FILL_W;
   localparam int CNT_W    = mcbf_pkg::CNT_W;
   localparam int ADDR_W   = mcbf_pkg::ADDR_W;
   localparam int COUNT_W  = mcbf_pkg::COUNT_W;
   localparam int SAMPLE_W = mcbf_pkg::SAMPLE_W;
   localparam int CHAN_W   = mcbf_pkg::CHAN_W;
   localparam int LIMIT_W  = mcbf_pkg::LIMIT_W;

   // control state
   mcbf_pkg::state_type       state_ff, state_in;
   logic [LIMIT_W-1:0]        limit_ff, limit_in;
   logic [COUNT_W-1:0]        batch_ff, batch_in;
   logic [PTR_W-1:0]          wr_ptr_ff [CHANNELS];
   logic [PTR_W-1:0]          wr_ptr_in [CHANNELS];
   logic [PTR_W-1:0]          rd_ptr_ff [CHANNELS];
   logic [PTR_W-1:0]          rd_ptr_in [CHANNELS];
   logic [FILL_W-1:0]         fill_ff [CHANNELS];
   logic [FILL_W-1:0]         fill_in [CHANNELS];
   logic [CHAN_W-1:0]         pull_ch_ff, pull_ch_in;
   logic [CNT_W-1:0]          remain_ff, remain_in;
   logic                      pend_ff, pend_in;
   logic [FILL_W-1:0]         pend_fill_ff, pend_fill_in;
   logic                      pend_last_ff, pend_last_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // result payload
   mcbf_pkg::kind_type        rsp_kind_ff, rsp_kind_in;
   logic                      rsp_acc_ff, rsp_acc_in;
   logic [COUNT_W-1:0]        rsp_batch_ff, rsp_batch_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]        rsp_fill_ff, rsp_fill_in;

   // handshake and sequencing controls
   logic                      out_free;
   logic                      accept;
   logic                      issue;
   logic                      move;
   logic                      rsp_load;

   // request decode
   logic                      is_push;
   logic                      ch_ok;
   logic [FILL_W-1:0]         cur_fill;
   logic                      has_room;
   logic [COUNT_W-1:0]        batch_nxt;
   logic [CNT_W-1:0]          lim_eff;
   logic [CNT_W-1:0]          pull_n;
   logic                      pull_empty;

   // memory ports
   logic                      ram_wr_en;
   logic [ADDR_W-1:0]         ram_wr_addr;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic [SAMPLE_W-1:0]       ram_rd_data;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // request decode
   always_comb begin
      is_push  = (req_type == mcbf_pkg::REQ_PUSH);
      ch_ok    = (int'(req_channel) < CHANNELS);
      cur_fill = ch_ok ? fill_ff[req_channel] : '0;
      has_room = ch_ok && (cur_fill < FILL_W'(mcbf_pkg::DEPTH));
      if (has_room && (batch_ff != mcbf_pkg::BATCH_SAT)) begin
         batch_nxt = batch_ff + 1'b1;
      end else begin
         batch_nxt = batch_ff;
      end
      // effective burst limit
      if (limit_ff == '0) begin
         lim_eff = CNT_W'(1);
      end else if (int'(limit_ff) > mcbf_pkg::MAX_BURST) begin
         lim_eff = CNT_W'(mcbf_pkg::MAX_BURST);
      end else begin
         lim_eff = CNT_W'(limit_ff);
      end
      pull_n     = (cur_fill < FILL_W'(lim_eff)) ? CNT_W'(cur_fill) : lim_eff;
      pull_empty = (cur_fill == '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcbf_pkg::ST_IDLE: begin
            if (accept && !is_push && !pull_empty) begin
               state_in = mcbf_pkg::ST_PULL;
            end
         end
         mcbf_pkg::ST_PULL: begin
            if (remain_ff == '0 && move) begin
               state_in = mcbf_pkg::ST_IDLE;
            end
         end
         default: state_in = mcbf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      move      = 1'b0;
      unique case (state_ff)
         mcbf_pkg::ST_IDLE: begin
            req_ready = out_free;
         end
         mcbf_pkg::ST_PULL: begin
            move  = pend_ff && out_free;
            issue = (remain_ff != '0) && (!pend_ff || out_free);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // memory addressing
   assign ram_wr_en   = accept && is_push && has_room;
   assign ram_wr_addr = mcbf_pkg::store_addr(req_channel, wr_ptr_ff[req_channel]);
   assign ram_rd_addr = mcbf_pkg::store_addr(pull_ch_ff, rd_ptr_ff[pull_ch_ff]);

   // per-channel pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (ram_wr_en) begin
         wr_ptr_in[req_channel] = (wr_ptr_ff[req_channel] == PTR_W'(mcbf_pkg::DEPTH - 1))
                                  ? '0 : wr_ptr_ff[req_channel] + 1'b1;
         fill_in[req_channel]   = fill_ff[req_channel] + 1'b1;
      end
      if (issue) begin
         rd_ptr_in[pull_ch_ff] = (rd_ptr_ff[pull_ch_ff] == PTR_W'(mcbf_pkg::DEPTH - 1))
                                 ? '0 : rd_ptr_ff[pull_ch_ff] + 1'b1;
         fill_in[pull_ch_ff]   = fill_ff[pull_ch_ff] - 1'b1;
      end
   end

   // burst bookkeeping and read-in-flight tracking
   always_comb begin
      pull_ch_in   = pull_ch_ff;
      remain_in    = remain_ff;
      pend_fill_in = pend_fill_ff;
      pend_last_in = pend_last_ff;
      pend_in      = issue || (pend_ff && !move);
      if (accept && !is_push) begin
         pull_ch_in = req_channel;
         remain_in  = pull_empty ? '0 : pull_n;
      end
      if (issue) begin
         remain_in    = remain_ff - 1'b1;
         pend_fill_in = fill_ff[pull_ch_ff] - 1'b1;
         pend_last_in = (remain_ff == CNT_W'(1));
      end
   end

   // batch count and configuration
   always_comb begin
      batch_in = batch_ff;
      limit_in = limit_ff;
      if (accept && is_push) begin
         batch_in = req_batch_end ? '0 : batch_nxt;
      end
      if (csr_valid && csr_ready) begin
         limit_in = csr_pull_limit;
      end
   end

   // result register load
   always_comb begin
      rsp_load      = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_batch_in  = rsp_batch_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_fill_in   = rsp_fill_ff;
      if (accept) begin
         rsp_load      = 1'b1;
         rsp_sample_in = '0;
         rsp_last_in   = 1'b1;
         if (is_push) begin
            rsp_kind_in  = mcbf_pkg::KIND_PUSH;
            rsp_acc_in   = has_room;
            rsp_batch_in = batch_nxt;
            rsp_fill_in  = has_room ? COUNT_W'(cur_fill + 1'b1) : COUNT_W'(cur_fill);
         end else begin
            rsp_kind_in  = mcbf_pkg::KIND_EMPTY;
            rsp_acc_in   = 1'b0;
            rsp_batch_in = '0;
            rsp_fill_in  = '0;
         end
      end else if (move) begin
         rsp_load      = 1'b1;
         rsp_kind_in   = mcbf_pkg::KIND_SAMPLE;
         rsp_acc_in    = 1'b0;
         rsp_batch_in  = '0;
         rsp_sample_in = $signed(ram_rd_data);
         rsp_last_in   = pend_last_ff;
         rsp_fill_in   = COUNT_W'(pend_fill_ff);
      end
      // a pull with data does not load a result at the transfer
      if (accept && !is_push && !pull_empty) begin
         rsp_load = 1'b0;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcbf_pkg::ST_IDLE;
         limit_ff     <= mcbf_pkg::LIMIT_RESET;
         batch_ff     <= '0;
         remain_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            wr_ptr_ff[i] <= '0;
            rd_ptr_ff[i] <= '0;
            fill_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         batch_ff     <= batch_in;
         remain_ff    <= remain_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pull_ch_ff    <= pull_ch_in;
      pend_fill_ff  <= pend_fill_in;
      pend_last_ff  <= pend_last_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_batch_ff  <= rsp_batch_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   // shared sample memory
   mcbf_ram #(
      .DATA_W (SAMPLE_W),
      .WORDS  (mcbf_pkg::WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_sample_in),
      .rd_en   (issue),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result ports
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_accepted       = rsp_acc_ff;
   assign rsp_batch_accepted = rsp_batch_ff;
   assign rsp_sample_out     = rsp_sample_ff;
   assign rsp_burst_last     = rsp_last_ff;
   assign rsp_fill_level     = rsp_fill_ff;

   // reads still owed never exceed samples stored in the channel
   a_remain_le_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == mcbf_pkg::ST_PULL |-> FILL_W'(remain_ff) <= fill_ff[pull_ch_ff])
      else $error("burst remainder exceeds channel fill");

   // read data waiting on a stalled output is kept
   a_pend_held: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !out_free |=> pend_ff)
      else $error("pending read data dropped");

   // last sample of a burst returns the sequencer to idle
   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      move && pend_last_ff |=> state_ff == mcbf_pkg::ST_IDLE)
      else $error("burst did not end on its last sample");

   // nothing of a burst is left over when requests are taken again
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == mcbf_pkg::ST_IDLE |-> !pend_ff && remain_ff == '0)
      else $error("idle with burst work outstanding");

endmodule

// ===== hdl/mcbf_ram.sv =====
// ----------------------------------------------------------------------------
// mcbf_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mcbf_ram #(
   parameter int DATA_W = 16,
   parameter int WORDS  = 1024
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(WORDS)-1:0]  wr_addr,
   input  logic [DATA_W-1:0]         wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(WORDS)-1:0]  rd_addr,
   output logic [DATA_W-1:0]         rd_data
);

   logic [DATA_W-1:0] mem_ff [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
